FILE: hw/rtl/btpc_pkg.sv
package btpc_pkg;

    localparam int CFG_W = 48;
    localparam int IDX_W = 2;

    localparam logic [IDX_W-1:0] REG_TEMP  = 2'd0;
    localparam logic [IDX_W-1:0] REG_PLOW  = 2'd1;
    localparam logic [IDX_W-1:0] REG_PMID  = 2'd2;
    localparam logic [IDX_W-1:0] REG_PHIGH = 2'd3;

    localparam logic signed [16:0] P_OFFSET = 17'sd16384;

    localparam logic [23:0] TEMP_MAX  = 24'h7F_FFFF;
    localparam logic [23:0] TEMP_MIN  = 24'h80_0000;
    localparam logic [25:0] PRESS_MAX = 26'h3FF_FFFF;

    typedef struct packed {
        logic        [15:0] t1;
        logic        [15:0] t2;
        logic signed [7:0]  t3;
        logic signed [16:0] p1;
        logic signed [16:0] p2;
        logic signed [7:0]  p3;
        logic signed [7:0]  p4;
        logic        [15:0] p5;
        logic        [15:0] p6;
        logic signed [7:0]  p7;
        logic signed [7:0]  p8;
        logic signed [15:0] p9;
        logic signed [7:0]  p10;
        logic signed [7:0]  p11;
    } coef_t;

    // round half up on a magnitude, shift s >= 1
    function automatic logic [95:0] rnd_mag(input logic [95:0] m, input int unsigned s);
        logic [95:0] half;
        half = 96'd1 << (s - 1);
        return (m + half) >> s;
    endfunction

    function automatic logic [7:0] abs8(input logic signed [7:0] v);
        return v[7] ? 8'(-v) : 8'(v);
    endfunction

    function automatic logic [15:0] abs17(input logic signed [16:0] v);
        return v[16] ? 16'(-v) : 16'(v);
    endfunction

endpackage

FILE: hw/rtl/baro_temp_pressure_compensation.sv
// Barometric temperature and pressure compensation.
// Input channel: in_valid/in_ready carry one press_sample, temp_sample pair.
// Output channel: out_valid/out_ready carry temperature_q16, pressure_q8 and
// saturated, one result per input, in order.
// Calibration words are written through cfg_we/cfg_index/cfg_data; the user
// must do so only while idle, as the block itself does not enforce it.
// The datapath has 16 stages (cascaded square, cube and split wide products).
// Throughput: one transfer per cycle on each side while the receiver keeps up.
// Each stage holds only while its successor is full and stalled, so a
// stalled receiver freezes the tail of the pipe while empty stages ahead of
// it keep taking inputs; in_ready drops only once every stage is full.
// Reset empties the pipeline and loads the calibration words as all zero.
module baro_temp_pressure_compensation
    import btpc_pkg::*;
#(
    parameter int TEMP_FRAC_BITS  = 16,
    parameter int PRESS_FRAC_BITS = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [23:0]         press_sample,
    input  logic [23:0]         temp_sample,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [23:0]  temperature_q16,
    output logic [25:0]         pressure_q8,
    output logic                saturated
);

    localparam int NS  = 16;
    localparam int TSH = 48 - TEMP_FRAC_BITS;
    localparam int PSH = 24 - PRESS_FRAC_BITS;

    coef_t cf;

    btpc_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (cf)
    );

    logic [NS:1] vld_reg;
    logic [NS:1] en;

    always_comb
    begin
        en[NS] = !vld_reg[NS] || out_ready;
        for (int k = NS - 1; k >= 1; k--)
            en[k] = !vld_reg[k] || en[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (en[1])
                vld_reg[1] <= in_valid;
            for (int k = 2; k <= NS; k++)
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    assign in_ready  = en[1];
    assign out_valid = vld_reg[NS];

    // carried payload
    logic        [23:0] up_reg    [1:12];
    logic        [47:0] up2_reg   [2:6];
    logic signed [32:0] upp11_reg [2:6];
    logic        [34:0] tqm_reg   [4:6];
    logic               tqn_reg   [4:8];
    logic        [23:0] tout_reg  [4:16];
    logic               tsat_reg  [4:15];
    logic signed [45:0] tp6_reg   [6:10];
    logic signed [46:0] tp2_reg   [6:10];
    logic signed [46:0] tp7_reg   [8:10];
    logic signed [46:0] tp3_reg   [8:10];
    logic signed [44:0] qt_reg    [8:14];
    logic signed [39:0] ct_reg    [8:14];
    logic signed [51:0] off_reg   [11:14];

    // stage 1: temperature offset
    logic signed [24:0] d_next;
    logic signed [24:0] d_reg;

    assign d_next = $signed({1'b0, temp_sample}) - $signed({1'b0, cf.t1, 8'd0});

    always_ff @(posedge clk)
    begin
        if (en[1])
            d_reg <= d_next;
    end

    // stage 2: first products
    logic        [23:0] dmag_next;
    logic signed [41:0] dt2_reg;
    logic        [47:0] dd_reg;

    assign dmag_next = d_reg[24] ? 24'(-d_reg) : 24'(d_reg);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            dt2_reg <= d_reg * $signed({1'b0, cf.t2});
            dd_reg  <= dmag_next * dmag_next;
        end
    end

    // stage 3: linearised temperature, Q48
    logic signed [56:0] ddt3_next;
    logic signed [59:0] tl_next;
    logic signed [59:0] tl_reg;

    assign ddt3_next = $signed({1'b0, dd_reg}) * $signed(cf.t3);
    assign tl_next   = $signed({dt2_reg, 18'd0}) + 60'(ddt3_next);

    always_ff @(posedge clk)
    begin
        if (en[3]) tl_reg <= tl_next;
    end

    // stage 4: Q24 temperature and output temperature
    logic        [58:0] tlm_next;
    logic        [34:0] tqm_next;
    logic signed [35:0] tq_next;
    logic        [31:0] toutm_next;
    logic        [23:0] tout_next;
    logic               tsat_next;
    logic signed [35:0] tq_reg;

    assign tlm_next   = tl_reg[59] ? 59'(-tl_reg) : 59'(tl_reg);
    assign tqm_next   = 35'(rnd_mag(96'(tlm_next), 24));
    assign tq_next    = tl_reg[59] ? -$signed({1'b0, tqm_next}) : $signed({1'b0, tqm_next});
    assign toutm_next = 32'(rnd_mag(96'(tlm_next), TSH));

    always_comb
    begin
        tsat_next = 1'b0;
        if (!tl_reg[59])
        begin
            if (toutm_next > 32'(TEMP_MAX))
            begin
                tout_next = TEMP_MAX;
                tsat_next = 1'b1;
            end
            else
                tout_next = 24'(toutm_next);
        end
        else
        begin
            if (toutm_next > 32'(TEMP_MIN))
            begin
                tout_next = TEMP_MIN;
                tsat_next = 1'b1;
            end
            else
                tout_next = 24'(-toutm_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
            tq_reg <= tq_next;
    end

    // stage 5: square partials, linear temperature products
    logic        [15:0] p2m_next;
    logic        [66:0] sqlo_reg;
    logic        [37:0] sqhi_reg;
    logic        [50:0] p6tq_reg;
    logic        [50:0] p2tq_reg;
    logic               p2tqn_reg;
    logic signed [43:0] p10tq_reg;

    assign p2m_next = abs17(cf.p2);

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            sqlo_reg  <= tqm_reg[4] * tqm_reg[4][31:0];
            sqhi_reg  <= tqm_reg[4] * tqm_reg[4][34:32];
            p6tq_reg  <= cf.p6 * tqm_reg[4];
            p2tq_reg  <= p2m_next * tqm_reg[4];
            p2tqn_reg <= cf.p2[16] ^ tqn_reg[4];
            p10tq_reg <= $signed(cf.p10) * tq_reg;
        end
    end

    // stage 6: square, P6 and P2 terms, quadratic coefficient
    logic        [95:0] sq_next;
    logic        [45:0] tsq_next;
    logic        [44:0] r6_next;
    logic        [45:0] r2_next;
    logic signed [44:0] quad_next;
    logic        [45:0] tsq_reg;
    logic        [43:0] qm_reg;
    logic               qn6_reg;

    assign sq_next   = 96'(sqlo_reg) + 96'({sqhi_reg, 32'd0});
    assign tsq_next  = 46'(rnd_mag(sq_next, 24));
    assign r6_next   = 45'(rnd_mag(96'(p6tq_reg), 6));
    assign r2_next   = 46'(rnd_mag(96'(p2tq_reg), 5));
    assign quad_next = 45'($signed({cf.p9, 24'd0})) + 45'(p10tq_reg);

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            tsq_reg <= tsq_next;
            qm_reg  <= quad_next[44] ? 44'(-quad_next) : 44'(quad_next);
            qn6_reg <= quad_next[44];
        end
    end

    // stage 7: cube partials, square products, raw-pressure partials
    logic [31:0] um_next;
    logic [66:0] tcul_reg;
    logic [48:0] tcuh_reg;
    logic [53:0] p7ts_reg;
    logic [53:0] p3ts_reg;
    logic [45:0] q00_reg;
    logic [45:0] q01_reg;
    logic [45:0] q10_reg;
    logic [45:0] q11_reg;
    logic [55:0] c0_reg;
    logic [55:0] c1_reg;
    logic        qn7_reg;
    logic        cn7_reg;

    assign um_next = upp11_reg[6][32] ? 32'(-upp11_reg[6]) : 32'(upp11_reg[6]);

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            tcul_reg <= tsq_reg[31:0] * tqm_reg[6];
            tcuh_reg <= tsq_reg[45:32] * tqm_reg[6];
            p7ts_reg <= abs8(cf.p7) * tsq_reg;
            p3ts_reg <= abs8(cf.p3) * tsq_reg;
            q00_reg  <= up2_reg[6][23:0] * qm_reg[21:0];
            q01_reg  <= up2_reg[6][23:0] * qm_reg[43:22];
            q10_reg  <= up2_reg[6][47:24] * qm_reg[21:0];
            q11_reg  <= up2_reg[6][47:24] * qm_reg[43:22];
            c0_reg   <= up2_reg[6][23:0] * um_next;
            c1_reg   <= up2_reg[6][47:24] * um_next;
            qn7_reg  <= qn6_reg;
            cn7_reg  <= upp11_reg[6][32];
        end
    end

    // stage 8: cube, P7 and P3 terms, second and third order pressure terms
    logic [55:0] tcum_next;
    logic [45:0] r7_next;
    logic [45:0] r3_next;
    logic [95:0] qsum_next;
    logic [43:0] qr_next;
    logic [95:0] csum_next;
    logic [38:0] cr_next;
    logic [55:0] tcum_reg;

    assign tcum_next = 56'(rnd_mag(96'(tcul_reg) + 96'({tcuh_reg, 32'd0}), 24));
    assign r7_next   = 46'(rnd_mag(96'(p7ts_reg), 8));
    assign r3_next   = 46'(rnd_mag(96'(p3ts_reg), 8));
    assign qsum_next = 96'(q00_reg) + 96'({q01_reg, 22'd0}) + 96'({q10_reg, 24'd0})
                     + 96'({q11_reg, 46'd0});
    assign qr_next   = 44'(rnd_mag(qsum_next, 48));
    assign csum_next = 96'(c0_reg) + 96'({c1_reg, 24'd0});
    assign cr_next   = 39'(rnd_mag(csum_next, 41));

    always_ff @(posedge clk)
    begin
        if (en[8])
            tcum_reg <= tcum_next;
    end

    // stage 9: cube products
    logic [63:0] p8tc_reg;
    logic [63:0] p4tc_reg;
    logic        p8n_reg;
    logic        p4n_reg;

    always_ff @(posedge clk)
    begin
        if (en[9])
        begin
            p8tc_reg <= abs8(cf.p8) * tcum_reg;
            p4tc_reg <= abs8(cf.p4) * tcum_reg;
            p8n_reg  <= cf.p8[7] ^ tqn_reg[8];
            p4n_reg  <= cf.p4[7] ^ tqn_reg[8];
        end
    end

    // stage 10: P8 and P4 terms
    logic        [48:0] r8_next;
    logic        [50:0] r4_next;
    logic signed [49:0] tp8_reg;
    logic signed [51:0] tp4_reg;

    assign r8_next = 49'(rnd_mag(96'(p8tc_reg), 15));
    assign r4_next = 51'(rnd_mag(96'(p4tc_reg), 13));

    always_ff @(posedge clk)
    begin
        if (en[10])
        begin
            tp8_reg <= p8n_reg ? -$signed({1'b0, r8_next}) : $signed({1'b0, r8_next});
            tp4_reg <= p4n_reg ? -$signed({1'b0, r4_next}) : $signed({1'b0, r4_next});
        end
    end

    // stage 11: offset and sensitivity
    logic signed [51:0] off_next;
    logic signed [53:0] sen_next;
    logic signed [53:0] sen_reg;

    assign off_next = 52'($signed({1'b0, cf.p5, 27'd0})) + 52'(tp6_reg[10])
                    + 52'(tp7_reg[10]) + 52'(tp8_reg);
    assign sen_next = 54'($signed({cf.p1, 28'd0})) + 54'(tp2_reg[10])
                    + 54'(tp3_reg[10]) + 54'(tp4_reg);

    always_ff @(posedge clk)
    begin
        if (en[11])
            sen_reg <= sen_next;
    end

    // stage 12: sensitivity magnitude
    logic [52:0] senm_reg;
    logic        senn12_reg;

    always_ff @(posedge clk)
    begin
        if (en[12])
        begin
            senm_reg   <= sen_reg[53] ? 53'(-sen_reg) : 53'(sen_reg);
            senn12_reg <= sen_reg[53];
        end
    end

    // stage 13: first order pressure partials
    logic [49:0] s0_reg;
    logic [50:0] s1_reg;
    logic        senn13_reg;

    always_ff @(posedge clk)
    begin
        if (en[13])
        begin
            s0_reg     <= up_reg[12] * senm_reg[25:0];
            s1_reg     <= up_reg[12] * senm_reg[52:26];
            senn13_reg <= senn12_reg;
        end
    end

    // stage 14: first order pressure term
    logic        [52:0] sr_next;
    logic signed [53:0] ts_reg;

    assign sr_next = 53'(rnd_mag(96'(s0_reg) + 96'({s1_reg, 26'd0}), 24));

    always_ff @(posedge clk)
    begin
        if (en[14])
            ts_reg <= senn13_reg ? -$signed({1'b0, sr_next}) : $signed({1'b0, sr_next});
    end

    // stage 15: pressure, Q24
    logic signed [55:0] p_next;
    logic signed [55:0] p_reg;

    assign p_next = 56'(off_reg[14]) + 56'(ts_reg) + 56'(qt_reg[14]) + 56'(ct_reg[14]);

    always_ff @(posedge clk)
    begin
        if (en[15]) p_reg <= p_next;
    end

    // stage 16: output scaling and clipping
    logic [54:0] pm_next;
    logic [43:0] pr_next;
    logic [25:0] pout_next;
    logic        psat_next;
    logic [25:0] pout_reg;
    logic        sat_reg;

    assign pm_next = p_reg[55] ? 55'(-p_reg) : 55'(p_reg);
    assign pr_next = 44'(rnd_mag(96'(pm_next), PSH));

    always_comb
    begin
        pout_next = '0;
        psat_next = 1'b0;
        if (p_reg[55])
            psat_next = (pr_next != '0);
        else if (pr_next > 44'(PRESS_MAX))
        begin
            pout_next = PRESS_MAX;
            psat_next = 1'b1;
        end
        else
            pout_next = 26'(pr_next);
    end

    always_ff @(posedge clk)
    begin
        if (en[16])
        begin
            pout_reg <= pout_next;
            sat_reg  <= psat_next || tsat_reg[15];
        end
    end

    // carried payload: entry at its producing stage, then one step per stage
    always_ff @(posedge clk)
    begin
        if (en[1])
            up_reg[1] <= press_sample;
        if (en[2])
        begin
            up2_reg[2]   <= up_reg[1] * up_reg[1];
            upp11_reg[2] <= $signed({1'b0, up_reg[1]}) * $signed(cf.p11);
        end
        if (en[4])
        begin
            tqm_reg[4]  <= tqm_next;
            tqn_reg[4]  <= tl_reg[59];
            tout_reg[4] <= tout_next;
            tsat_reg[4] <= tsat_next;
        end
        if (en[6])
        begin
            tp6_reg[6] <= tqn_reg[5] ? -$signed({1'b0, r6_next}) : $signed({1'b0, r6_next});
            tp2_reg[6] <= p2tqn_reg ? -$signed({1'b0, r2_next}) : $signed({1'b0, r2_next});
        end
        if (en[8])
        begin
            tp7_reg[8] <= cf.p7[7] ? -$signed({1'b0, r7_next}) : $signed({1'b0, r7_next});
            tp3_reg[8] <= cf.p3[7] ? -$signed({1'b0, r3_next}) : $signed({1'b0, r3_next});
            qt_reg[8]  <= qn7_reg ? -$signed({1'b0, qr_next}) : $signed({1'b0, qr_next});
            ct_reg[8]  <= cn7_reg ? -$signed({1'b0, cr_next}) : $signed({1'b0, cr_next});
        end
        if (en[11])
            off_reg[11] <= off_next;
        for (int k = 2; k <= 12; k++)
            if (en[k]) up_reg[k] <= up_reg[k-1];
        for (int k = 3; k <= 6; k++)
            if (en[k])
            begin
                up2_reg[k]   <= up2_reg[k-1];
                upp11_reg[k] <= upp11_reg[k-1];
            end
        for (int k = 5; k <= 6; k++)
            if (en[k]) tqm_reg[k] <= tqm_reg[k-1];
        for (int k = 5; k <= 8; k++)
            if (en[k]) tqn_reg[k] <= tqn_reg[k-1];
        for (int k = 5; k <= 16; k++)
            if (en[k]) tout_reg[k] <= tout_reg[k-1];
        for (int k = 5; k <= 15; k++)
            if (en[k]) tsat_reg[k] <= tsat_reg[k-1];
        for (int k = 7; k <= 10; k++)
            if (en[k])
            begin
                tp6_reg[k] <= tp6_reg[k-1];
                tp2_reg[k] <= tp2_reg[k-1];
            end
        for (int k = 9; k <= 10; k++)
            if (en[k])
            begin
                tp7_reg[k] <= tp7_reg[k-1];
                tp3_reg[k] <= tp3_reg[k-1];
            end
        for (int k = 9; k <= 14; k++)
            if (en[k])
            begin
                qt_reg[k] <= qt_reg[k-1];
                ct_reg[k] <= ct_reg[k-1];
            end
        for (int k = 12; k <= 14; k++)
            if (en[k]) off_reg[k] <= off_reg[k-1];
    end

    assign temperature_q16 = $signed(tout_reg[16]);
    assign pressure_q8     = pout_reg;
    assign saturated       = sat_reg;

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output stage");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (&vld_reg))
        else $error("input stalled while a stage is empty");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |->
            (temperature_q16 == $signed(TEMP_MAX) || temperature_q16 == $signed(TEMP_MIN)
             || pressure_q8 == '0 || pressure_q8 == PRESS_MAX))
        else $error("saturation flag without a clipped result");

endmodule

FILE: hw/rtl/btpc_cfg.sv
module btpc_cfg
    import btpc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output coef_t            coef
);

    coef_t coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg    <= '0;
            coef_reg.p1 <= -P_OFFSET;
            coef_reg.p2 <= -P_OFFSET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TEMP:
                begin
                    coef_reg.t1 <= cfg_data[15:0];
                    coef_reg.t2 <= cfg_data[31:16];
                    coef_reg.t3 <= $signed(cfg_data[39:32]);
                end
                REG_PLOW:
                begin
                    coef_reg.p1 <= 17'($signed(cfg_data[15:0])) - P_OFFSET;
                    coef_reg.p2 <= 17'($signed(cfg_data[31:16])) - P_OFFSET;
                    coef_reg.p3 <= $signed(cfg_data[39:32]);
                    coef_reg.p4 <= $signed(cfg_data[47:40]);
                end
                REG_PMID:
                begin
                    coef_reg.p5 <= cfg_data[15:0];
                    coef_reg.p6 <= cfg_data[31:16];
                    coef_reg.p7 <= $signed(cfg_data[39:32]);
                    coef_reg.p8 <= $signed(cfg_data[47:40]);
                end
                REG_PHIGH:
                begin
                    coef_reg.p9  <= $signed(cfg_data[15:0]);
                    coef_reg.p10 <= $signed(cfg_data[23:16]);
                    coef_reg.p11 <= $signed(cfg_data[31:24]);
                end
            endcase
        end
    end

    assign coef = coef_reg;

endmodule

FILE: tb/baro_temp_pressure_compensation_checker.sv
module baro_temp_pressure_compensation_checker
    import btpc_pkg::*;
#(
    parameter int TEMP_FRAC_BITS  = 16,
    parameter int PRESS_FRAC_BITS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [23:0]        press_sample,
    input  logic [23:0]        temp_sample,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [23:0] temperature_q16,
    input  logic [25:0]        pressure_q8,
    input  logic               saturated,
    output int                 fail_count,
    output int                 pending,
    output int                 checked,
    output int                 sat_seen
);

    typedef struct packed {
        logic [23:0] temp;
        logic [25:0] press;
        logic        sat;
    } comp_result_t;

    logic [39:0] temp_words;
    logic [47:0] plow_words;
    logic [47:0] pmid_words;
    logic [31:0] phigh_words;

    comp_result_t expected_results[$];

    // R(a*b / 2^s), half away from zero, clipped to the 64-bit range
    function automatic longint mul_round(input longint a, input longint b, input int s);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] prod;
        logic [63:0]  r;
        bit           neg;
        bit           ovf;
        neg  = (a < 0) != (b < 0);
        ua   = a < 0 ? -a : a;
        ub   = b < 0 ? -b : b;
        prod = {64'd0, ua} * {64'd0, ub};
        if (s != 0)
            prod = prod + (128'd1 << (s - 1));
        prod = prod >> s;
        r    = prod[63:0];
        ovf  = prod[127:64] != 0;
        if (ovf || r[63])
            r = 64'h7FFF_FFFF_FFFF_FFFF;
        return neg ? -$signed(r) : $signed(r);
    endfunction

    function automatic comp_result_t compensate(input logic [23:0] up_raw,
                                                input logic [23:0] ut_raw);
        longint up, ut, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
        longint d, tl, tq, tsq, tcu, off, sen, up2, quad, p, tout, pout;
        comp_result_t res;
        up   = longint'(up_raw);
        ut   = longint'(ut_raw);
        t1   = longint'(temp_words[15:0]);
        t2   = longint'(temp_words[31:16]);
        t3   = longint'($signed(temp_words[39:32]));
        p1   = longint'($signed(plow_words[15:0])) - 16384;
        p2   = longint'($signed(plow_words[31:16])) - 16384;
        p3   = longint'($signed(plow_words[39:32]));
        p4   = longint'($signed(plow_words[47:40]));
        p5   = longint'(pmid_words[15:0]);
        p6   = longint'(pmid_words[31:16]);
        p7   = longint'($signed(pmid_words[39:32]));
        p8   = longint'($signed(pmid_words[47:40]));
        p9   = longint'($signed(phigh_words[15:0]));
        p10  = longint'($signed(phigh_words[23:16]));
        p11  = longint'($signed(phigh_words[31:24]));
        d    = ut - t1 * 256;
        tl   = d * t2 * 262144 + d * d * t3;
        tq   = mul_round(tl, 1, 24);
        tsq  = mul_round(tq, tq, 24);
        tcu  = mul_round(tsq, tq, 24);
        off  = p5 * (64'sd1 <<< 27) + mul_round(p6, tq, 6)
             + mul_round(p7, tsq, 8) + mul_round(p8, tcu, 15);
        sen  = p1 * (64'sd1 <<< 28) + mul_round(p2, tq, 5)
             + mul_round(p3, tsq, 8) + mul_round(p4, tcu, 13);
        up2  = up * up;
        quad = p9 * (64'sd1 <<< 24) + p10 * tq;
        p    = off + mul_round(up, sen, 24) + mul_round(up2, quad, 48)
             + mul_round(up2, up * p11, 41);
        tout = mul_round(tl, 1, 48 - TEMP_FRAC_BITS);
        pout = mul_round(p, 1, 24 - PRESS_FRAC_BITS);
        res.sat = 1'b0;
        if (tout > 8388607) begin
            tout = 8388607;
            res.sat = 1'b1;
        end
        else if (tout < -8388608) begin
            tout = -8388608;
            res.sat = 1'b1;
        end
        if (pout < 0) begin
            pout = 0;
            res.sat = 1'b1;
        end
        else if (pout > 67108863) begin
            pout = 67108863;
            res.sat = 1'b1;
        end
        res.temp  = tout[23:0];
        res.press = pout[25:0];
        return res;
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        comp_result_t exp_res;
        int           errs;
        errs = 0;
        if (!rst_n) begin
            temp_words  <= '0;
            plow_words  <= '0;
            pmid_words  <= '0;
            phigh_words <= '0;
            fail_count  <= 0;
            checked     <= 0;
            sat_seen    <= 0;
            expected_results.delete();
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_TEMP:  temp_words  <= cfg_data[39:0];
                    REG_PLOW:  plow_words  <= cfg_data[47:0];
                    REG_PMID:  pmid_words  <= cfg_data[47:0];
                    REG_PHIGH: phigh_words <= cfg_data[31:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_results.push_back(compensate(press_sample, temp_sample));
            if (out_valid && out_ready) begin
                checked <= checked + 1;
                if (saturated)
                    sat_seen <= sat_seen + 1;
                if (expected_results.size() == 0) begin
                    $error("unexpected result transfer");
                    errs = errs + 1;
                end
                else begin
                    exp_res = expected_results.pop_front();
                    if (temperature_q16 !== exp_res.temp) begin
                        $error("temperature_q16 expected %0d actual %0d",
                               $signed(exp_res.temp), temperature_q16);
                        errs = errs + 1;
                    end
                    if (pressure_q8 !== exp_res.press) begin
                        $error("pressure_q8 expected %0d actual %0d",
                               exp_res.press, pressure_q8);
                        errs = errs + 1;
                    end
                    if (saturated !== exp_res.sat) begin
                        $error("saturated expected %0b actual %0b",
                               exp_res.sat, saturated);
                        errs = errs + 1;
                    end
                end
                fail_count <= fail_count + errs;
            end
        end
    end

endmodule

FILE: tb/baro_temp_pressure_compensation_tb.sv
module baro_temp_pressure_compensation_tb;
    import btpc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LATENCY     = 16;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [23:0]        press_sample;
    logic [23:0]        temp_sample;
    logic               out_valid;
    logic               out_ready;
    logic signed [23:0] temperature_q16;
    logic [25:0]        pressure_q8;
    logic               saturated;
    logic               hold_go;

    int fail_count;
    int pending;
    int checked;
    int sat_seen;
    int cycles;
    int items_sent;
    int t1_word;

    baro_temp_pressure_compensation dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .press_sample    (press_sample),
        .temp_sample     (temp_sample),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .temperature_q16 (temperature_q16),
        .pressure_q8     (pressure_q8),
        .saturated       (saturated)
    );

    baro_temp_pressure_compensation_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .press_sample    (press_sample),
        .temp_sample     (temp_sample),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .temperature_q16 (temperature_q16),
        .pressure_q8     (pressure_q8),
        .saturated       (saturated),
        .fail_count      (fail_count),
        .pending         (pending),
        .checked         (checked),
        .sat_seen        (sat_seen)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("baro_temp_pressure_compensation regression: fail");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off when requested
    initial
    begin : receiver
        int hold;
        int gap;
        bit held;
        hold = 0;
        held = 0;
        gap  = 0;
        out_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_go && !held) begin
                held = 1;
                hold = 300;
            end
            if (hold > 0) begin
                hold = hold - 1;
                out_ready <= 1'b0;
            end
            else if (gap > 0) begin
                gap = gap - 1;
                out_ready <= 1'b0;
            end
            else if (out_ready && $urandom_range(0, 9) < 3) begin
                gap = gap_len();
                out_ready <= (gap == 0);
            end
            else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic load_coeffs(input logic [47:0] tw, input logic [47:0] lw,
                               input logic [47:0] mw, input logic [47:0] hw);
        write_reg(REG_TEMP, tw);
        write_reg(REG_PLOW, lw);
        write_reg(REG_PMID, mw);
        write_reg(REG_PHIGH, hw);
        t1_word = int'(tw[15:0]);
    endtask

    task automatic send_pair(input logic [23:0] up, input logic [23:0] ut, input bit no_gap);
        int gap;
        in_valid     <= 1'b1;
        press_sample <= up;
        temp_sample  <= ut;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        gap = no_gap ? 0 : gap_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic random_pairs(input int n, input bit no_gap);
        logic [23:0] up;
        logic [23:0] ut;
        int          base;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 7) begin
                base = t1_word * 256;
                ut = 24'(base + $signed($urandom_range(0, 2097152)) - 1048576);
                up = 24'($urandom_range(3000000, 9000000));
            end
            else begin
                ut = 24'($urandom);
                up = 24'($urandom);
            end
            send_pair(up, ut, no_gap);
        end
    endtask

    initial
    begin
        logic [47:0] tw;
        logic [47:0] lw;
        logic [47:0] mw;
        logic [47:0] hw;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        press_sample = '0;
        temp_sample  = '0;
        hold_go      = 1'b0;
        cycles       = 0;
        items_sent   = 0;
        t1_word      = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // plausible calibration, upper bits beyond the register width set
        tw = {8'hA5, 8'(-8'sd10), 16'd19000, 16'd27000};
        lw = {8'sd2, 8'sd30, 16'(-16'sd6000), 16'(-16'sd8000)};
        mw = {8'(-8'sd5), 8'sd3, 16'd29000, 16'd25000};
        hw = {16'hFFFF, 8'(-8'sd60), 8'sd10, 16'sd16000};
        load_coeffs(tw, lw, mw, hw);
        send_pair(24'd0, 24'd0, 0);
        send_pair(24'hFFFFFF, 24'hFFFFFF, 0);
        send_pair(24'd0, 24'hFFFFFF, 0);
        send_pair(24'hFFFFFF, 24'd0, 1);
        send_pair(24'd6000000, 24'(27000 * 256), 1);
        send_pair(24'd6000000, 24'(27000 * 256 + 1), 0);
        send_pair(24'd6000000, 24'(27000 * 256 - 1), 0);
        send_pair(24'hAAAAAA, 24'h555555, 0);
        send_pair(24'h555555, 24'hAAAAAA, 0);
        send_pair(24'h800000, 24'h800000, 0);
        send_pair(24'h7FFFFF, 24'h7FFFFF, 0);
        send_pair(24'd1, 24'd1, 0);
        random_pairs(80, 0);
        drain();

        // reset values written explicitly
        load_coeffs('0, '0, '0, '0);
        send_pair(24'hFFFFFF, 24'hFFFFFF, 0);
        send_pair(24'd0, 24'd0, 0);
        random_pairs(60, 0);
        drain();

        // every bit set: signed words at minus one, largest unsigned
        load_coeffs('1, '1, '1, '1);
        send_pair(24'hFFFFFF, 24'hFFFFFF, 0);
        send_pair(24'd0, 24'd0, 0);
        random_pairs(60, 0);
        drain();

        // largest positive signed words
        load_coeffs({8'h00, 8'h7F, 16'hFFFF, 16'hFFFF}, {8'h7F, 8'h7F, 16'h7FFF, 16'h7FFF},
                    {8'h7F, 8'h7F, 16'hFFFF, 16'hFFFF}, {16'h0, 8'h7F, 8'h7F, 16'h7FFF});
        send_pair(24'hFFFFFF, 24'hFFFFFF, 0);
        send_pair(24'd0, 24'd0, 0);
        random_pairs(60, 0);
        drain();

        // back-to-back offer while the receiver holds off: pipe fills up
        load_coeffs(tw, lw, mw, hw);
        hold_go <= 1'b1;
        random_pairs(120, 1);
        random_pairs(40, 0);
        drain();

        for (int k = 0; k < 4; k++) begin
            load_coeffs(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                        48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
            random_pairs(45, 0);
            drain();
        end

        $display("%0d sample pairs sent over 9 calibration sets, %0d results checked",
                 items_sent, checked);
        $display("%0d results clipped, one long receiver hold-off", sat_seen);
        if (fail_count == 0)
            $display("baro_temp_pressure_compensation regression: pass");
        else
            $display("baro_temp_pressure_compensation regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/btpc_pkg.sv
hw/rtl/btpc_cfg.sv
hw/rtl/baro_temp_pressure_compensation.sv
tb/baro_temp_pressure_compensation_checker.sv
tb/baro_temp_pressure_compensation_tb.sv
